// ----- design/assert_macros.svh -----
// Assertion macros shared by the ADPCM block decoder modules.
// Defining NO_ASSERTIONS turns every use into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ADBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ADBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ADBD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ADBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/adbd_pkg.sv -----
// Types, constants and the sample arithmetic of the ADPCM block decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package adbd_pkg;

	localparam int VOICES   = 24;
	localparam int VOICE_W  = 5;
	localparam int VOICE_AW = (VOICES > 1) ? $clog2(VOICES) : 1;

	localparam logic [3:0] POS_HEADER = 4'd0;
	localparam logic [3:0] POS_FLAGS  = 4'd1;
	localparam logic [3:0] POS_FIRST_DATA = 4'd2;

	localparam logic [3:0] SHIFT_MAX     = 4'd12;
	localparam logic [3:0] SHIFT_FALLBACK = 4'd9;
	localparam logic [2:0] FILTER_MAX    = 3'd4;
	localparam logic [4:0] LAST_INDEX    = 5'd27;

	localparam logic signed [20:0] SAMPLE_MAX = 21'sd32767;
	localparam logic signed [20:0] SAMPLE_MIN = -21'sd32768;

	// Per-voice state, one memory entry.
	typedef struct packed {
		logic signed [15:0] h1;
		logic signed [15:0] h2;
		logic [3:0]         shift;
		logic [2:0]         filter;
		logic [2:0]         flags;
		logic [3:0]         pos;
	} state_t;

	typedef struct packed {
		logic                en;
		logic [VOICE_AW-1:0] voice;
		state_t              data;
	} wr_t;

	function automatic logic signed [7:0] coef_pos(input logic [2:0] fi);
		logic signed [7:0] c;
		case (fi)
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			3'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [7:0] coef_neg(input logic [2:0] fi);
		logic signed [7:0] c;
		case (fi)
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			3'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	// One sample: scaled nibble plus the filtered prediction, clamped to 16 bits.
	function automatic logic signed [15:0] decode_sample(
		input logic signed [15:0] h1,
		input logic signed [15:0] h2,
		input logic [3:0]         sh,
		input logic [2:0]         fi,
		input logic [3:0]         nib
	);
		logic signed [16:0] t;
		logic signed [25:0] acc;
		logic signed [25:0] biased;
		logic signed [19:0] pred;
		logic signed [20:0] sum;
		logic signed [15:0] res;
		t = $signed({{13{nib[3]}}, nib}) <<< (SHIFT_MAX - sh);
		acc = 26'(h1) * 26'(coef_pos(fi)) + 26'(h2) * 26'(coef_neg(fi)) + 26'sd32;
		// Division by 64 rounds toward zero, so negative values get a bias first.
		biased = acc + (acc[25] ? 26'sd63 : 26'sd0);
		pred = 20'(biased >>> 6);
		sum = 21'(t) + 21'(pred);
		if (sum > SAMPLE_MAX) begin
			res = 16'sh7FFF;
		end else if (sum < SAMPLE_MIN) begin
			res = 16'sh8000;
		end else begin
			res = sum[15:0];
		end
		return res;
	endfunction

endpackage

// ----- design/adbd_state_ram.sv -----
// Per-voice state memory of the ADPCM block decoder: one read and one write
// port, registered read, valid bits for reset and write forwarding. Uses adbd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adbd_state_ram
	import adbd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [VOICE_AW-1:0] rd_voice,
	output state_t              rd_state,
	input  wr_t                 wr
);

	state_t              mem [VOICES];
	logic [VOICES-1:0]   vld_q;
	state_t              rd_data_q;
	logic                rd_vld_q;
	logic [VOICE_AW-1:0] rd_voice_q;
	state_t              fwd_data_q;
	logic [VOICE_AW-1:0] fwd_voice_q;
	logic                fwd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.voice] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_voice];
			rd_voice_q <= rd_voice;
		end
		if (wr.en) begin
			fwd_data_q  <= wr.data;
			fwd_voice_q <= wr.voice;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.voice] <= 1'b1;
				fwd_vld_q       <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_voice];
			end
		end
	end

	// A write in the same cycle as the read is not seen by the array output,
	// so the most recent write is kept aside and wins on a voice match.
	always_comb begin
		if (fwd_vld_q && (fwd_voice_q == rd_voice_q)) begin
			rd_state = fwd_data_q;
		end else if (rd_vld_q) begin
			rd_state = rd_data_q;
		end else begin
			rd_state = '0;
		end
	end

	`ADBD_ASSERT_NEXT(a_fwd_tracks_write, clk, arst_n, wr.en, fwd_vld_q && (fwd_voice_q == $past(wr.voice)))
	`ADBD_ASSERT_NEXT(a_write_sets_valid, clk, arst_n, wr.en, vld_q[$past(wr.voice)])
	`ADBD_ASSERT_IMP(a_fwd_implies_written, clk, arst_n, fwd_vld_q, vld_q[fwd_voice_q])

endmodule

// ----- design/adbd_decode_unit.sv -----
// Two-phase decode unit: reads the voice state, decodes one sample per phase
// through a shared multiply-accumulate, writes the state back. Uses adbd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adbd_decode_unit
	import adbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ld,
	input  logic [VOICE_W-1:0] ld_voice,
	input  logic [7:0]         ld_byte,
	input  logic               ld_start,
	output logic               ready,
	input  state_t             rd_state,
	output wr_t                wr,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,  // voice_out[4:0], sample[20:5], sample_index[25:21]
	output logic               m_tlast,
	output logic [7:0]         m_tuser   // block_end, loop start, loop end, loop repeat, stop
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FIRST  = 3'b010,
		PH_SECOND = 3'b100
	} phase_t;

	phase_t             ph_q;
	logic [VOICE_W-1:0] voice_s1;
	logic [7:0]         byte_s1;
	logic               start_s1;
	state_t             wk_q;
	logic               wk_data_q;

	logic               m_tvalid_q;
	logic [VOICE_W-1:0] out_voice_q;
	logic signed [15:0] out_sample_q;
	logic [4:0]         out_idx_q;
	logic               out_last_q;
	logic [2:0]         out_flags_q;

	logic [3:0]         pos_eff;
	logic               is_data;
	state_t             wk_d;
	state_t             op;
	logic [3:0]         nib;
	logic signed [15:0] smp;
	logic               out_free;
	logic               adv_first;
	logic               adv_second;
	logic               out_load;
	logic [3:0]         data_pos;

	always_comb begin
		pos_eff = start_s1 ? POS_HEADER : rd_state.pos;
		is_data = (pos_eff != POS_HEADER) && (pos_eff != POS_FLAGS);

		if (ph_q == PH_SECOND) begin
			op  = wk_q;
			nib = byte_s1[7:4];
		end else begin
			op  = rd_state;
			nib = byte_s1[3:0];
		end
		smp = decode_sample(op.h1, op.h2, op.shift, op.filter, nib);

		wk_d = rd_state;
		if (pos_eff == POS_HEADER) begin
			wk_d.shift  = (byte_s1[3:0] > SHIFT_MAX) ? SHIFT_FALLBACK : byte_s1[3:0];
			wk_d.filter = (byte_s1[6:4] > FILTER_MAX) ? FILTER_MAX : byte_s1[6:4];
			wk_d.pos    = POS_FLAGS;
		end else if (pos_eff == POS_FLAGS) begin
			wk_d.flags = byte_s1[2:0];
			wk_d.pos   = POS_FIRST_DATA;
		end else begin
			wk_d.h2 = rd_state.h1;
			wk_d.h1 = smp;
		end

		out_free   = !m_tvalid_q || m_tready;
		adv_first  = !is_data || out_free;
		adv_second = !wk_data_q || out_free;
		out_load   = ((ph_q == PH_FIRST) && is_data && out_free) ||
			((ph_q == PH_SECOND) && wk_data_q && out_free);
		ready      = (ph_q == PH_IDLE) || ((ph_q == PH_SECOND) && adv_second);

		wr.en    = (ph_q == PH_SECOND) && adv_second;
		wr.voice = voice_s1[VOICE_AW-1:0];
		wr.data  = wk_q;
		if (wk_data_q) begin
			wr.data.h2  = wk_q.h1;
			wr.data.h1  = smp;
			wr.data.pos = wk_q.pos + 4'd1;
		end

		data_pos = op.pos - POS_FIRST_DATA;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			unique case (ph_q)
				PH_IDLE: begin
					if (ld) ph_q <= PH_FIRST;
				end
				PH_FIRST: begin
					if (adv_first) ph_q <= PH_SECOND;
				end
				PH_SECOND: begin
					if (adv_second) ph_q <= ld ? PH_FIRST : PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			voice_s1 <= ld_voice;
			byte_s1  <= ld_byte;
			start_s1 <= ld_start;
		end
		if ((ph_q == PH_FIRST) && adv_first) begin
			wk_q      <= wk_d;
			wk_data_q <= is_data;
		end
		if (out_load) begin
			out_voice_q  <= voice_s1;
			out_sample_q <= smp;
			out_idx_q    <= {data_pos, ph_q == PH_SECOND};
			out_last_q   <= (ph_q == PH_SECOND);
			out_flags_q  <= op.flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_idx_q, out_sample_q, out_voice_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {3'd0,
		out_flags_q[0] && !out_flags_q[1],
		out_flags_q[1],
		out_flags_q[0],
		out_flags_q[2],
		out_idx_q == LAST_INDEX};

	`ADBD_ASSERT_IMP(a_no_accept_in_first, clk, arst_n, ph_q == PH_FIRST, !ready)
	`ADBD_ASSERT_IMP(a_index_in_range, clk, arst_n, m_tvalid_q, out_idx_q <= LAST_INDEX)
	`ADBD_ASSERT_IMP(a_block_end_is_high, clk, arst_n, m_tvalid_q && (out_idx_q == LAST_INDEX), out_last_q)
	`ADBD_ASSERT_NEXT(a_low_then_high, clk, arst_n, (ph_q == PH_FIRST) && is_data && out_free, (ph_q == PH_SECOND) && m_tvalid_q && !out_last_q)

endmodule

// ----- design/adpcm_block_sample_decoder_core.sv -----
// Multi-voice block ADPCM decoder top level. Depends on adbd_pkg, adbd_state_ram
// and adbd_decode_unit.
`timescale 1ns / 1ps

// Takes one block byte per input word, tagged with a voice, and returns two
// 16-bit samples per data byte (low nibble first, tlast on the second); header
// and flag bytes update the voice and return nothing, and words for voices at
// or above the voice count are taken and dropped. Every in-range word passes through
// the decode unit's first and second phases, one per pass through its shared
// multiply-accumulate; a new word is taken in the cycle the previous one writes its
// state back, and neither phase moves on while a data sample waits on the output.
// Voice state lives in one memory with a registered read; after reset every voice
// reads as zero through per-entry valid bits, so no clearing pass is needed.
module adpcm_block_sample_decoder_core
	import adbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // voice[4:0], data_byte[12:5]
	input  logic [0:0]  s_tuser,   // block_start[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // voice_out[4:0], sample[20:5], sample_index[25:21]
	output logic        m_tlast,   // last
	output logic [7:0]  m_tuser    // block_end, loop start, loop end, loop repeat, stop_voice
);

	logic [VOICE_W-1:0] in_voice;
	logic               in_range;
	logic               ld;
	state_t             rd_state;
	wr_t                wr;

	assign in_voice = s_tdata[VOICE_W-1:0];
	assign in_range = {1'b0, in_voice} < (VOICE_W + 1)'(VOICES);
	assign ld       = s_tvalid && s_tready && in_range;

	adbd_state_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (ld),
		.rd_voice (in_voice[VOICE_AW-1:0]),
		.rd_state (rd_state),
		.wr       (wr)
	);

	adbd_decode_unit u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.ld_voice (in_voice),
		.ld_byte  (s_tdata[12:5]),
		.ld_start (s_tuser[0]),
		.ready    (s_tready),
		.rd_state (rd_state),
		.wr       (wr),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- tb/adpcm_block_sample_decoder_core_tb.sv -----
// Self-checking testbench for the multi-voice ADPCM block decoder core.
// Depends on adbd_pkg and adpcm_block_sample_decoder_core; predicts every decoded sample itself.
`timescale 1ns / 1ps

module adpcm_block_sample_decoder_core_tb
	import adbd_pkg::*;
();

	localparam int WATCHDOG_CYCLES = 3000;
	localparam int RANDOM_WORDS    = 1350;
	localparam int DRAIN_CYCLES    = 30;

	typedef struct packed {
		bit         sync;
		logic       start;
		logic [7:0] data;
		logic [4:0] voice;
	} block_word_t;

	typedef struct {
		int voice;
		int pcm;
		int idx;
		int hi;
		int blk_end;
		int flag_start;
		int flag_end;
		int flag_repeat;
		int stop;
	} pcm_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;    // voice[4:0], data_byte[12:5]
	logic [0:0]  s_tuser = '0;    // block_start[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // voice_out[4:0], sample[20:5], sample_index[25:21]
	logic        m_tlast;         // last
	logic [7:0]  m_tuser;         // block_end, loop start, loop end, loop repeat, stop_voice

	// Per-voice decoder state as the predictor sees it.
	int hist_last [VOICES];
	int hist_prev [VOICES];
	int blk_shift [VOICES];
	int blk_filter[VOICES];
	int blk_flags [VOICES];
	int blk_pos   [VOICES];
	int gain_recent[5] = '{0, 60, 115, 98, 122};
	int gain_older [5] = '{0, 0, -52, -55, -60};

	// Byte position of each voice as the stimulus generator tracks it.
	int gen_pos[32];

	block_word_t word_queue[$];
	block_word_t cur_word;
	pcm_exp_t    pcm_expected[$];

	int errors = 0;
	int words_taken = 0;
	int words_dropped = 0;
	int pcm_seen = 0;
	int blocks_done = 0;
	int clamped = 0;
	int gap_left = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit long_hold_done = 1'b0;

	adpcm_block_sample_decoder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none at all while steady.
	function automatic int random_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic int next_pcm(input int v, input int nib);
		int t;
		int pred;
		int s;
		t = (nib >= 8) ? nib - 16 : nib;
		t = t * (1 << (12 - blk_shift[v]));
		// Integer division truncates toward zero, as the hardware must.
		pred = (hist_last[v] * gain_recent[blk_filter[v]]
			+ hist_prev[v] * gain_older[blk_filter[v]] + 32) / 64;
		s = t + pred;
		if (s > 32767 || s < -32768) begin
			clamped++;
		end
		if (s > 32767) begin
			s = 32767;
		end else if (s < -32768) begin
			s = -32768;
		end
		hist_prev[v] = hist_last[v];
		hist_last[v] = s;
		return s;
	endfunction

	// Applies one accepted word to the voice state and queues the samples it yields.
	function automatic void decode_word(input block_word_t w);
		int v;
		int pos;
		int sh;
		int fi;
		pcm_exp_t e;
		v = int'(w.voice);
		if (v >= VOICES) begin
			words_dropped++;
			return;
		end
		if (w.start) begin
			blk_pos[v] = 0;
		end
		pos = blk_pos[v];
		if (pos == 0) begin
			sh = int'(w.data[3:0]);
			fi = int'(w.data[6:4]);
			blk_shift[v] = (sh > 12) ? 9 : sh;
			blk_filter[v] = (fi > 4) ? 4 : fi;
			blk_pos[v] = 1;
			return;
		end
		if (pos == 1) begin
			blk_flags[v] = int'(w.data[2:0]);
			blk_pos[v] = 2;
			return;
		end
		for (int n = 0; n < 2; n++) begin
			e.voice = v;
			e.pcm = next_pcm(v, n ? int'(w.data[7:4]) : int'(w.data[3:0]));
			e.idx = (pos - 2) * 2 + n;
			e.hi = n;
			e.blk_end = int'(e.idx == 27);
			e.flag_start = (blk_flags[v] >> 2) & 1;
			e.flag_end = blk_flags[v] & 1;
			e.flag_repeat = (blk_flags[v] >> 1) & 1;
			e.stop = int'(e.flag_end && !e.flag_repeat);
			pcm_expected.push_back(e);
		end
		blk_pos[v] = (pos + 1) % 16;
	endfunction

	task automatic push_word(input int v, input int data, input bit start);
		block_word_t w;
		w.sync = 1'b0;
		w.voice = 5'(v);
		w.data = 8'(data);
		w.start = start;
		word_queue.push_back(w);
		if (v < VOICES) begin
			gen_pos[v] = start ? 1 : (gen_pos[v] + 1) % 16;
		end
	endtask

	task automatic push_sync();
		block_word_t w;
		w = '0;
		w.sync = 1'b1;
		word_queue.push_back(w);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// Stimulus: a directed opening, then mostly well-formed interleaved blocks.
	initial begin
		int r;
		int v;
		int in_range;
		bit mid_sync_done;
		in_range = 0;
		mid_sync_done = 1'b0;
		for (int i = 0; i < VOICES; i++) begin
			hist_last[i] = 0;
			hist_prev[i] = 0;
			blk_shift[i] = 0;
			blk_filter[i] = 0;
			blk_flags[i] = 0;
			blk_pos[i] = 0;
		end
		for (int i = 0; i < 32; i++) begin
			gen_pos[i] = 0;
		end

		// Largest nibbles at the smallest shift, all flags set.
		push_word(0, 8'h00, 1'b1);
		push_word(0, 8'h07, 1'b0);
		push_word(0, 8'h78, 1'b0);
		push_word(0, 8'hF0, 1'b0);
		// Filter one drives the sum past both clamp limits.
		push_word(1, 8'h10, 1'b1);
		push_word(1, 8'h02, 1'b0);
		push_word(1, 8'h77, 1'b0);
		push_word(1, 8'h88, 1'b0);
		push_word(1, 8'h88, 1'b0);
		// Out-of-range shift and filter fall back to nine and four; stop flag.
		push_word(23, 8'hFF, 1'b1);
		push_word(23, 8'h01, 1'b0);
		push_word(23, 8'h7F, 1'b0);
		push_word(23, 8'h09, 1'b0);
		// Voices past the voice count are dropped.
		push_word(24, 8'h5A, 1'b1);
		push_word(31, 8'hFF, 1'b0);
		// Header taken without the start mark, largest legal shift.
		push_word(2, 8'h4C, 1'b0);
		push_word(2, 8'h04, 1'b0);
		push_word(2, 8'hE3, 1'b0);
		push_word(2, 8'h1F, 1'b0);
		// Restart of voice zero in the middle of its block keeps the history.
		push_word(0, 8'h2D, 1'b1);
		push_word(0, 8'h05, 1'b0);
		push_word(0, 8'hA5, 1'b0);
		push_word(3, 8'h3C, 1'b0);
		push_word(3, 8'h00, 1'b0);
		push_word(3, 8'h81, 1'b0);
		push_sync();

		while (in_range < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 84) begin
				v = $urandom_range(0, VOICES - 1);
				if (gen_pos[v] == 0) begin
					push_word(v, {$urandom_range(0, 1) == 1 ? 1'b1 : 1'b0,
						3'($urandom_range(0, 7)),
						4'($urandom_range(0, 9) == 0 ? $urandom_range(13, 15)
							: $urandom_range(0, 12))},
						$urandom_range(0, 3) != 0);
				end else begin
					push_word(v, $urandom_range(0, 255), 1'b0);
				end
			end else if (r < 94) begin
				v = $urandom_range(0, 31);
				push_word(v, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
			end else begin
				v = $urandom_range(0, VOICES - 1);
				push_word(v, $urandom_range(0, 255), 1'b1);
			end
			if (v < VOICES) begin
				in_range++;
			end
			if (!mid_sync_done && in_range >= RANDOM_WORDS / 2) begin
				mid_sync_done = 1'b1;
				push_sync();
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() > 0 || s_tvalid || pcm_expected.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pcm_expected.size() > 0) begin
			errors++;
			$display("%0t: %0d expected samples never arrived", $time, pcm_expected.size());
		end
		$display("Run covered %0d words (%0d for absent voices) and %0d samples,",
			words_taken, words_dropped, pcm_seen);
		$display("including %0d completed blocks and %0d clamped samples.", blocks_done, clamped);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Sender: offers queued words, idles at random, and halts at sync marks until drained.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			decode_word(cur_word);
			words_taken++;
		end
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if ($urandom_range(0, 99) == 0) begin
				tx_steady = !tx_steady;
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (word_queue.size() > 0 && word_queue[0].sync) begin
				s_tvalid <= 1'b0;
				if (pcm_expected.size() == 0) begin
					void'(word_queue.pop_front());
				end
			end else if (word_queue.size() > 0) begin
				cur_word = word_queue.pop_front();
				s_tdata <= {3'b000, cur_word.data, cur_word.voice};
				s_tuser <= cur_word.start;
				s_tvalid <= 1'b1;
				gap_left = random_gap(tx_steady);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: checks each sample against the oldest prediction and stalls at random.
	always @(posedge clk) begin
		pcm_exp_t want;
		int n;
		if (m_tvalid && m_tready) begin
			pcm_seen++;
			if (m_tuser[0]) begin
				blocks_done++;
			end
			if (pcm_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected sample, expected none, got voice %0d value %0d",
					$time, m_tdata[4:0], $signed(m_tdata[20:5]));
			end else begin
				want = pcm_expected.pop_front();
				check_field("voice", want.voice, int'(m_tdata[4:0]));
				check_field("sample", want.pcm, int'($signed(m_tdata[20:5])));
				check_field("sample index", want.idx, int'(m_tdata[25:21]));
				check_field("last", want.hi, int'(m_tlast));
				check_field("block end", want.blk_end, int'(m_tuser[0]));
				check_field("loop start", want.flag_start, int'(m_tuser[1]));
				check_field("loop end", want.flag_end, int'(m_tuser[2]));
				check_field("loop repeat", want.flag_repeat, int'(m_tuser[3]));
				check_field("stop voice", want.stop, int'(m_tuser[4]));
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!long_hold_done && pcm_seen >= 600) begin
			// Long hold-off so the decoder fills up and stalls its input.
			long_hold_done = 1'b1;
			hold_left = 500;
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0) begin
				rx_steady = !rx_steady;
			end
			n = random_gap(rx_steady);
			if (n > 0) begin
				hold_left = n - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_CYCLES);
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
+incdir+design
design/adbd_pkg.sv
design/adbd_state_ram.sv
design/adbd_decode_unit.sv
design/adpcm_block_sample_decoder_core.sv
tb/adpcm_block_sample_decoder_core_tb.sv
